// File: design/pls_pkg.sv
// Shared types and codes for the positional list store.
package pls_pkg;

  localparam int WORD_W = 32;
  localparam int POS_W  = 7;
  localparam int IDX_W  = 6;
  localparam int CNT_W  = 7;

  typedef enum logic [2:0] {
    OP_CLEAR  = 3'd0,
    OP_INSERT = 3'd1,
    OP_DELETE = 3'd2,
    OP_GET    = 3'd3,
    OP_FIND   = 3'd4
  } opcode_t;

  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_INVALID = 2'd1;
  localparam logic [1:0] ST_NOTHING = 2'd2;

  typedef struct packed {
    logic [2:0]               opcode;
    logic signed [WORD_W-1:0] value;
    logic [POS_W-1:0]         position;
  } req_t;

  typedef struct packed {
    logic [1:0]               status;
    logic signed [WORD_W-1:0] value_out;
    logic [IDX_W-1:0]         index_out;
    logic [CNT_W-1:0]         count;
  } rsp_t;

endpackage

// File: design/pls_ram.sv
// Entry memory of the positional list store: one write port, one registered read port.
module pls_ram #(
  parameter int DEPTH = 64,
  parameter int AW    = 6
) (
  input  logic                      clk,
  input  logic                      we,
  input  logic [AW-1:0]             waddr,
  input  logic [pls_pkg::WORD_W-1:0] wdata,
  input  logic                      re,
  input  logic [AW-1:0]             raddr,
  output logic [pls_pkg::WORD_W-1:0] rdata
);
  import pls_pkg::*;

  logic [WORD_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// File: design/positional_list_store.sv
// Top level of the positional list store: sequencer, length count and result register.
//
// The block keeps an ordered list of up to CAPACITY signed 32-bit words in one
// synchronous memory and executes one operation per request transaction:
// clear, insert at a position, delete at a position, get at a position, and
// find the first entry greater than a key. Every request yields exactly one
// response transaction carrying a status, the removed or read word, the index
// found, and the list length after the operation. Requests are processed one
// at a time. Clear and rejected requests go straight to the finishing step;
// get, insert, delete and find walk the memory, insert and delete over the
// list tail (length minus position), find over the entries examined
// up to the match or up to the full length. The walk moves one entry per cycle
// through the memory's single read port and single write port; in an insert or
// delete, read and write are pipelined so that each cycle reads one entry and
// writes the one read in the previous cycle. A finished response waits in an
// output register, so the next request is accepted while it is still pending.
// Entries never written are never read, so the memory needs no clearing pass
// after reset; reset clears the length count, the state and the valid flags.
module positional_list_store #(
  parameter int CAPACITY = 64
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          req_valid,
  output logic          req_ready,
  input  pls_pkg::req_t req,
  output logic          rsp_valid,
  input  logic          rsp_ready,
  output pls_pkg::rsp_t rsp
);
  import pls_pkg::*;

  localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CW = $clog2(CAPACITY + 1);
  localparam int XW = (CW > POS_W) ? CW : POS_W;

  typedef enum logic [1:0] {
    IDLE,
    WALK,
    FINISH
  } state_t;

  state_t                   state;
  opcode_t                  op;
  logic signed [WORD_W-1:0] key;
  logic [AW-1:0]            pos_r;
  logic [CW-1:0]            count;
  logic [CW-1:0]            left;
  logic [AW-1:0]            rp;
  logic [AW-1:0]            prev;
  logic                     rv;
  logic [1:0]               res_status;
  logic signed [WORD_W-1:0] res_value;
  logic [IDX_W-1:0]         res_index;

  // Memory port controls.
  logic                     we;
  logic [AW-1:0]            waddr;
  logic [WORD_W-1:0]        wdata;
  logic                     re;
  logic [AW-1:0]            raddr;
  logic [WORD_W-1:0]        rdata;

  logic                     found;
  logic                     issue;
  logic                     walk_done;
  logic [XW-1:0]            pos_x;
  logic [XW-1:0]            cnt_x;

  assign req_ready = (state == IDLE);
  assign pos_x     = XW'(req.position);
  assign cnt_x     = XW'(count);

  // A find stops at the first entry that compares greater than the key.
  assign found     = (state == WALK) && rv && (op == OP_FIND) &&
                     ($signed(rdata) > key);
  assign issue     = (state == WALK) && (left != '0) && !found;
  assign walk_done = (state == WALK) && (left == '0) && !rv;

  // During an insert or delete walk each cycle reads the next entry and writes
  // back the entry read in the previous cycle one place away. The read and the
  // write are always two addresses apart, so no forwarding is needed.
  always_comb begin
    we    = 1'b0;
    waddr = prev;
    wdata = rdata;
    re    = issue;
    raddr = rp;
    if (state == WALK) begin
      if (rv) begin
        case (op)
          OP_INSERT: begin
            we    = 1'b1;
            waddr = AW'(prev + AW'(1));
          end
          OP_DELETE: begin
            if (prev != pos_r) begin
              we    = 1'b1;
              waddr = AW'(prev - AW'(1));
            end
          end
          default: begin
            we = 1'b0;
          end
        endcase
      end else if (walk_done && (op == OP_INSERT)) begin
        // All later entries have moved up; the new word lands at its position.
        we    = 1'b1;
        waddr = pos_r;
        wdata = key;
      end
    end
  end

  pls_ram #(
    .DEPTH(CAPACITY),
    .AW   (AW)
  ) u_ram (
    .clk  (clk),
    .we   (we),
    .waddr(waddr),
    .wdata(wdata),
    .re   (re),
    .raddr(raddr),
    .rdata(rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= IDLE;
      count     <= '0;
      rv        <= 1'b0;
      rsp_valid <= 1'b0;
    end else begin
      // A taken response is dropped here unless the finishing step reloads it.
      if (rsp_valid && rsp_ready && (state != FINISH)) begin
        rsp_valid <= 1'b0;
      end
      unique case (state)
        IDLE: begin
          if (req_valid) begin
            op         <= opcode_t'(req.opcode);
            key        <= req.value;
            pos_r      <= AW'(req.position);
            rv         <= 1'b0;
            res_status <= ST_INVALID;
            res_value  <= '0;
            res_index  <= '0;
            state      <= FINISH;
            case (req.opcode)
              OP_CLEAR: begin
                count      <= '0;
                res_status <= ST_OK;
              end
              OP_INSERT: begin
                if ((pos_x <= cnt_x) && (count < CW'(CAPACITY))) begin
                  res_status <= ST_OK;
                  left       <= CW'(cnt_x - pos_x);
                  rp         <= AW'(count - CW'(1));
                  state      <= WALK;
                end
              end
              OP_DELETE: begin
                if (pos_x < cnt_x) begin
                  res_status <= ST_OK;
                  left       <= CW'(cnt_x - pos_x);
                  rp         <= AW'(req.position);
                  state      <= WALK;
                end
              end
              OP_GET: begin
                if (pos_x < cnt_x) begin
                  res_status <= ST_OK;
                  left       <= CW'(1);
                  rp         <= AW'(req.position);
                  state      <= WALK;
                end
              end
              OP_FIND: begin
                res_status <= ST_NOTHING;
                left       <= count;
                rp         <= '0;
                state      <= WALK;
              end
              default: begin
                res_status <= ST_INVALID;
              end
            endcase
          end
        end
        WALK: begin
          // Capture the word read at the requested position.
          if (rv && (prev == pos_r) && ((op == OP_DELETE) || (op == OP_GET))) begin
            res_value <= $signed(rdata);
          end
          if (found) begin
            res_status <= ST_OK;
            res_index  <= IDX_W'(prev);
            rv         <= 1'b0;
            state      <= FINISH;
          end else if (issue) begin
            rv   <= 1'b1;
            prev <= rp;
            left <= left - CW'(1);
            rp   <= (op == OP_INSERT) ? AW'(rp - AW'(1)) : AW'(rp + AW'(1));
          end else begin
            rv <= 1'b0;
            if (walk_done) begin
              if (op == OP_INSERT) begin
                count <= count + CW'(1);
              end else if (op == OP_DELETE) begin
                count <= count - CW'(1);
              end
              state <= FINISH;
            end
          end
        end
        FINISH: begin
          if (!rsp_valid || rsp_ready) begin
            rsp_valid     <= 1'b1;
            rsp.status    <= res_status;
            rsp.value_out <= res_value;
            rsp.index_out <= res_index;
            rsp.count     <= CNT_W'(count);
            state         <= IDLE;
          end
        end
        default: begin
          state <= IDLE;
        end
      endcase
    end
  end

  // The length never exceeds the capacity.
  a_count_range: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(CAPACITY))
    else $error("list length above capacity");

  // A walk never reads and writes the same entry in one cycle.
  a_no_rw_collision: assert property (@(posedge clk) disable iff (rst)
    (re && we) |-> (raddr != waddr))
    else $error("memory read and write collide");

  // A new response is only launched from the finishing step.
  a_rsp_from_finish: assert property (@(posedge clk) disable iff (rst)
    $rose(rsp_valid) |-> $past(state == FINISH))
    else $error("response raised outside finish");

  // Memory traffic happens only while walking the list.
  a_mem_only_walk: assert property (@(posedge clk) disable iff (rst)
    (re || we) |-> (state == WALK))
    else $error("memory access outside walk");

endmodule

// File: bench/positional_list_store_test.sv
// Self-checking testbench for the positional list store, with a built-in list predictor.
`timescale 1ns / 1ps

// The testbench keeps its own copy of the list and works out the response to every
// request transaction at the moment the block accepts it. A separate process takes
// response transactions and compares them field by field, in order, with the
// oldest predicted response. Both channels stall at random. The receiver also holds
// off for a long stretch once, so that the block fills up and stops taking requests.
module positional_list_store_test;
  import pls_pkg::*;

  localparam int CAP = 64;

  // Opcodes outside the defined set. The block must refuse them and leave the list alone.
  localparam logic [2:0] OP_RSVD5 = 3'd5;
  localparam logic [2:0] OP_RSVD6 = 3'd6;
  localparam logic [2:0] OP_RSVD7 = 3'd7;

  localparam int IDLE_PCT      = 20;    // percent of cycles in which a side idles
  localparam int HOLD_CYCLES   = 400;   // the long receiver hold-off
  localparam int STALL_LIMIT   = 4000;  // cycles with no transaction before giving up
  localparam int TAIL_CYCLES   = 100;   // quiet time after the last response
  localparam int RANDOM_ITEMS  = 1530;
  localparam int NO_IDLE_ITEMS = 300;   // opening stretch of the random part runs flat out
  localparam int CHUNK         = 100;   // random items per traffic mix
  localparam int MAX_REPORTS   = 40;

  // Traffic mixes for the random part. Growing and shrinking runs push the list to
  // its full and empty ends, and churn keeps it somewhere in the middle.
  typedef enum logic [1:0] {
    MIX_GROW,
    MIX_SHRINK,
    MIX_CHURN
  } mix_t;

  logic  clk = 1'b0;
  logic  rst = 1'b1;
  logic  req_valid = 1'b0;
  logic  req_ready;
  req_t  req = '0;
  logic  rsp_valid;
  logic  rsp_ready = 1'b0;
  rsp_t  rsp;

  // Predictor state: the entries of the list and its length.
  logic signed [WORD_W-1:0] list_words [CAP];
  int                       list_len = 0;

  rsp_t        pending_results [$];
  rsp_t        oldest;
  logic        offering = 1'b0;   // shadow of req_valid as last driven
  logic        idle_on = 1'b1;
  logic        hold_req = 1'b0;
  int unsigned hold_left = 0;
  int unsigned stall_cycles = 0;
  int unsigned errors = 0;
  int unsigned items_sent = 0;
  int unsigned results_checked = 0;
  int unsigned full_refusals = 0;

  always #5 clk = ~clk;

  positional_list_store #(
    .CAPACITY(CAP)
  ) uut (
    .clk(clk),
    .rst(rst),
    .req_valid(req_valid),
    .req_ready(req_ready),
    .req(req),
    .rsp_valid(rsp_valid),
    .rsp_ready(rsp_ready),
    .rsp(rsp)
  );

  // Applies one operation to the predicted list and returns the response the block
  // owes for it. Fields without meaning for the operation stay zero.
  function automatic rsp_t list_op_result(req_t op_item);
    rsp_t res;
    int   p;
    int   i;
    res = '0;
    res.status = ST_INVALID;
    p = int'(op_item.position);
    case (op_item.opcode)
      OP_CLEAR: begin
        list_len = 0;
        res.status = ST_OK;
      end
      OP_INSERT: begin
        if (list_len >= CAP) begin
          full_refusals++;
        end else if (p <= list_len) begin
          // Open a gap at the position, moving the entry there up as well.
          for (i = list_len; i > p; i--) list_words[i] = list_words[i - 1];
          list_words[p] = op_item.value;
          list_len++;
          res.status = ST_OK;
        end
      end
      OP_DELETE: begin
        if (p < list_len) begin
          res.value_out = list_words[p];
          for (i = p; i + 1 < list_len; i++) list_words[i] = list_words[i + 1];
          list_len--;
          res.status = ST_OK;
        end
      end
      OP_GET: begin
        if (p < list_len) begin
          res.value_out = list_words[p];
          res.status = ST_OK;
        end
      end
      OP_FIND: begin
        // Signed comparison: the first entry strictly greater than the key wins.
        res.status = ST_NOTHING;
        for (i = 0; i < list_len; i++) begin
          if (op_item.value < list_words[i]) begin
            res.index_out = i[IDX_W-1:0];
            res.status = ST_OK;
            break;
          end
        end
      end
      default: begin
        // Reserved opcodes are refused with the list untouched.
      end
    endcase
    res.count = list_len[CNT_W-1:0];
    return res;
  endfunction

  // Lowers the request valid if it is up. Only ever called at a clock edge.
  task automatic pause_requests();
    if (offering) begin
      req_valid <= 1'b0;
      offering = 1'b0;
    end
  endtask

  // Offers one request transaction and returns at the edge where it is accepted.
  // The valid is left high, so back-to-back requests need no extra assignment;
  // a random gap lowers it first, so one edge never sees two assignments to it.
  task automatic send_op(logic [2:0] op, logic signed [WORD_W-1:0] val,
                         logic [POS_W-1:0] pos);
    req_t item;
    item.opcode = op;
    item.value = val;
    item.position = pos;
    if (idle_on && $urandom_range(0, 99) < IDLE_PCT) begin
      pause_requests();
      do @(posedge clk); while ($urandom_range(0, 99) < 40);
    end
    req_valid <= 1'b1;
    req <= item;
    offering = 1'b1;
    do @(posedge clk); while (!req_ready);
    pending_results.push_back(list_op_result(item));
    items_sent++;
  endtask

  // Stops offering requests until every predicted response has come back.
  task automatic drain_results();
    pause_requests();
    do @(posedge clk); while (pending_results.size() != 0);
  endtask

  // Picks a word: mostly anything, often a small value so that finds land on
  // interesting neighbours, sometimes a word already in the list, and the extremes.
  function automatic logic signed [WORD_W-1:0] pick_value();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 45) return $urandom;
    if (roll < 75) return $urandom_range(0, 40) - 20;
    if (roll < 90 && list_len > 0) return list_words[$urandom_range(0, list_len - 1)];
    if (roll < 95) return 32'h7fff_ffff;
    return 32'h8000_0000;
  endfunction

  // Position below span most of the time, otherwise one at or past it, up to the
  // top of the field, so that refusals and the high position bit are exercised.
  function automatic logic [POS_W-1:0] pick_position(int span);
    if (span > 0 && $urandom_range(0, 99) < 94) return POS_W'($urandom_range(0, span - 1));
    return POS_W'($urandom_range(span, 127));
  endfunction

  task automatic send_random_op(mix_t mix);
    int roll;
    int ins_pct;
    int del_pct;
    case (mix)
      MIX_GROW: begin
        ins_pct = 70;
        del_pct = 10;
      end
      MIX_SHRINK: begin
        ins_pct = 10;
        del_pct = 70;
      end
      default: begin
        ins_pct = 40;
        del_pct = 35;
      end
    endcase
    roll = $urandom_range(0, 99);
    if (roll < 5) begin
      // Noise: any opcode, any word, any position.
      send_op(3'($urandom_range(0, OP_RSVD7)), $urandom, POS_W'($urandom_range(0, 127)));
    end else if (roll < 6) begin
      send_op(OP_CLEAR, $urandom, POS_W'($urandom));
    end else begin
      roll = $urandom_range(0, 99);
      if (roll < ins_pct)
        send_op(OP_INSERT, pick_value(), pick_position(list_len + 1));
      else if (roll < ins_pct + del_pct)
        send_op(OP_DELETE, $urandom, pick_position(list_len));
      else if (roll < ins_pct + del_pct + (100 - ins_pct - del_pct) / 2)
        send_op(OP_GET, $urandom, pick_position(list_len));
      else
        send_op(OP_FIND, pick_value(), POS_W'($urandom));
    end
  endtask

  // Every operation on an empty list, plus an insert past the end and a reserved opcode.
  task automatic test_empty_list();
    send_op(OP_CLEAR, '0, '0);
    send_op(OP_GET, '0, '0);
    send_op(OP_DELETE, '0, '0);
    send_op(OP_FIND, '0, '0);
    send_op(OP_INSERT, 32'h1234_5678, 7'd1);
    send_op(OP_RSVD5, 32'hffff_ffff, '0);
  endtask

  // Extreme words, positions at and past the ends, and finds that hit, miss and
  // skip over an equal entry.
  task automatic test_corner_values();
    send_op(OP_INSERT, 32'h7fff_ffff, 7'd0);
    send_op(OP_INSERT, 32'h8000_0000, 7'd0);
    send_op(OP_INSERT, 32'hffff_ffff, 7'd1);
    send_op(OP_INSERT, 32'h0000_0000, 7'd3);
    // The list now reads: most negative, -1, most positive, 0.
    send_op(OP_INSERT, 32'h5555_5555, 7'd5);
    send_op(OP_GET, '0, 7'd3);
    send_op(OP_GET, '0, 7'd4);
    send_op(OP_GET, '0, 7'd127);
    send_op(OP_FIND, 32'h8000_0000, '0);
    send_op(OP_FIND, 32'h7fff_ffff, '0);
    send_op(OP_FIND, 32'hffff_ffff, '0);
    send_op(OP_DELETE, '0, 7'd0);
    send_op(OP_DELETE, '0, 7'd2);
    send_op(OP_DELETE, '0, 7'd64);
    send_op(OP_RSVD6, 32'h7fff_ffff, 7'd0);
    send_op(OP_RSVD7, 32'h8000_0000, 7'd127);
    send_op(OP_CLEAR, '0, 7'd127);
  endtask

  // The receiver holds off for a long stretch while inserts keep coming, so the
  // block backs up and stalls its input. The list is driven past full, then its
  // last slot and the positions beyond it are probed.
  task automatic test_backpressure_fill();
    send_op(OP_CLEAR, '0, '0);
    hold_req = 1'b1;
    repeat (CAP + 6) send_op(OP_INSERT, pick_value(), POS_W'($urandom_range(0, list_len)));
    send_op(OP_INSERT, $urandom, 7'd0);
    send_op(OP_INSERT, $urandom, POS_W'(CAP));
    send_op(OP_GET, '0, POS_W'(CAP - 1));
    send_op(OP_GET, '0, POS_W'(CAP));
    send_op(OP_FIND, 32'h7fff_ffff, '0);
    send_op(OP_FIND, 32'h8000_0000, '0);
    send_op(OP_DELETE, '0, POS_W'(CAP - 1));
    send_op(OP_DELETE, '0, 7'd0);
    drain_results();
  endtask

  // The sender goes quiet until every response is in, then starts again.
  task automatic test_pause_until_drained();
    repeat (8) send_random_op(MIX_CHURN);
    drain_results();
    send_op(OP_GET, '0, '0);
    send_op(OP_FIND, pick_value(), '0);
    drain_results();
  endtask

  // Long random run in chunks of one traffic mix each. It opens with a stretch in
  // which neither side idles, and now and then the sender waits for the block to empty.
  task automatic test_random_mix(int unsigned total);
    int unsigned n;
    mix_t        mix;
    mix = MIX_CHURN;
    idle_on = 1'b0;
    for (n = 0; n < total; n++) begin
      if (n == NO_IDLE_ITEMS) idle_on = 1'b1;
      if (n % CHUNK == 0) begin
        if (n != 0 && $urandom_range(0, 2) == 0) drain_results();
        mix = mix_t'($urandom_range(0, 2));
      end
      send_random_op(mix);
    end
    drain_results();
  endtask

  // Receiver: random stalls, or the long hold-off when one is asked for. The
  // hold-off is counted here so the sender can go on offering requests meanwhile.
  always @(posedge clk) begin
    if (hold_left == 0 && hold_req) begin
      hold_left = HOLD_CYCLES;
      hold_req = 1'b0;
    end
    if (hold_left != 0) begin
      hold_left--;
      rsp_ready <= 1'b0;
    end else begin
      rsp_ready <= !idle_on || ($urandom_range(0, 99) >= IDLE_PCT);
    end
  end

  function automatic void check_field(string name, logic [WORD_W-1:0] want,
                                      logic [WORD_W-1:0] got);
    if (want !== got) begin
      errors++;
      if (errors <= MAX_REPORTS)
        $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
    end
  endfunction

  // Response checker and activity counter for the watchdog. Signals are read at
  // the edge, before any of this edge's assignments take effect.
  always @(posedge clk) begin
    if ((req_valid && req_ready) || (rsp_valid && rsp_ready))
      stall_cycles = 0;
    else
      stall_cycles++;
    if (!rst && rsp_valid && rsp_ready) begin
      results_checked++;
      if (pending_results.size() == 0) begin
        errors++;
        if (errors <= MAX_REPORTS)
          $display("%0t: unexpected response, expected none, actual %0h", $time, rsp);
      end else begin
        oldest = pending_results.pop_front();
        check_field("status", WORD_W'(oldest.status), WORD_W'(rsp.status));
        check_field("value_out", oldest.value_out, rsp.value_out);
        check_field("index_out", WORD_W'(oldest.index_out), WORD_W'(rsp.index_out));
        check_field("count", WORD_W'(oldest.count), WORD_W'(rsp.count));
      end
    end
  end

  initial begin : watchdog
    do @(posedge clk); while (stall_cycles < STALL_LIMIT);
    $display("%0t: no transaction for %0d cycles", $time, STALL_LIMIT);
    $display("Some tests failed");
    $finish;
  end

  initial begin : main
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    test_empty_list();
    test_corner_values();
    test_backpressure_fill();
    test_pause_until_drained();
    test_random_mix(RANDOM_ITEMS);
    repeat (TAIL_CYCLES) @(posedge clk);
    if (pending_results.size() != 0) begin
      errors++;
      $display("%0t: %0d responses never arrived", $time, pending_results.size());
    end
    $display("Ran %0d operations and compared %0d responses, %0d field errors.",
             items_sent, results_checked, errors);
    $display("The list was driven past full (%0d inserts refused) under a %0d-cycle hold-off.",
             full_refusals, HOLD_CYCLES);
    if (errors == 0)
      $display("All tests passed");
    else
      $display("Some tests failed");
    $finish;
  end

endmodule

// File: filelist.f
design/pls_pkg.sv
design/pls_ram.sv
design/positional_list_store.sv
bench/positional_list_store_test.sv
